// File: sv/inertial_scroll_physics_top_macros.svh
// Assertion macros used by the RTL file inertial_scroll_physics_top.sv.
`ifndef INERTIAL_SCROLL_PHYSICS_TOP_MACROS_SVH
`define INERTIAL_SCROLL_PHYSICS_TOP_MACROS_SVH

// Same-cycle implication on clk, disabled while arst_n is low.
`define ISP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, disabled while arst_n is low.
`define ISP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/isp_pkg.sv
package isp_pkg;

	localparam int ISP_FRAC_BITS = 16;
	localparam int ISP_WIDE_W    = 40;
	localparam int ISP_ADDR_W    = 3;
	localparam int ISP_LIM_W     = 15;

	localparam logic [2:0] ISP_KIND_DOWN = 3'd0;
	localparam logic [2:0] ISP_KIND_MOVE = 3'd1;
	localparam logic [2:0] ISP_KIND_UP   = 3'd2;
	localparam logic [2:0] ISP_KIND_TICK = 3'd3;
	localparam logic [2:0] ISP_KIND_SET  = 3'd4;

	localparam logic ISP_REG_MAX_X = 1'b0;
	localparam logic ISP_REG_MAX_Y = 1'b1;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
	} isp_item_t;

	typedef struct packed {
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic               redraw;
		logic               animating;
		logic               dragging_now;
	} isp_result_t;

endpackage

// File: sv/inertial_scroll_physics_top.sv
// Two-axis inertial scroll engine with spring-back, offsets in signed fixed point with
// FRAC_BITS fraction bits. Each transferred item (touch down, move, up, tick or set offset)
// yields exactly one result carrying both offsets and the redraw, animating and dragging
// flags. One item is taken every clock; its result is offered from the result register once
// the item has passed the input register, where the single state-update pass computes the
// result register from it. That pass, which reads and writes the scroll state for every
// item, sets the rate of one item per cycle; a stalled result holds the input register and
// then the input channel. Limits are written through the APB port at 0x0 (x) and 0x4 (y)
// in whole pixels.
`include "inertial_scroll_physics_top_macros.svh"

module inertial_scroll_physics_top #(
	parameter int FRAC_BITS = isp_pkg::ISP_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [isp_pkg::ISP_ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  isp_pkg::isp_item_t            item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output isp_pkg::isp_result_t          result
);
	import isp_pkg::*;

	localparam int W = ISP_WIDE_W;
	localparam logic signed [31:0] MIN_SPEED = 32'((64'sd1 <<< FRAC_BITS) / 5);
	localparam logic signed [32:0] SNAP_DIST = 33'((64'sd1 <<< FRAC_BITS) / 4);
	localparam logic [32:0] HALF_UNIT = 33'((64'sd1 <<< FRAC_BITS) / 2);
	localparam logic [31:0] INT_MASK = ~(32'((64'sd1 <<< FRAC_BITS) - 1));

	typedef struct packed {
		logic signed [31:0] off;
		logic signed [31:0] spd;
		logic               act;
	} axis_t;

	function automatic logic signed [W-1:0] ext16(input logic signed [15:0] v);
		return $signed({{(W-16){v[15]}}, v});
	endfunction

	function automatic logic signed [W-1:0] ext32(input logic signed [31:0] v);
		return $signed({{(W-32){v[31]}}, v});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
		logic signed [W-1:0] hi;
		logic signed [W-1:0] lo;
		hi = ext32(32'sh7fffffff);
		lo = ext32(32'sh80000000);
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] half_rate(input logic signed [31:0] raw,
			input logic signed [31:0] lim);
		logic signed [32:0] t;
		if (raw < 0) begin
			t = $signed({raw[31], raw}) + $signed({32'd0, raw[31]});
			t = t >>> 1;
			return t[31:0];
		end
		if (raw > lim) begin
			t = $signed({raw[31], raw}) - $signed({lim[31], lim});
			t = $signed({lim[31], lim}) + (t >>> 1);
			return t[31:0];
		end
		return raw;
	endfunction

	function automatic axis_t step_axis(input logic signed [31:0] off,
			input logic signed [31:0] spd, input logic signed [31:0] lim);
		axis_t r;
		logic signed [32:0] tgt;
		logic signed [32:0] dlt;
		logic signed [32:0] noff;
		logic signed [36:0] fr;
		logic signed [36:0] frs;
		logic signed [31:0] ns;
		logic [32:0] rnd;
		r.off = off;
		r.spd = spd;
		r.act = 1'b0;
		tgt = (off < 0) ? 33'sd0 : $signed({lim[31], lim});
		if (off < 0 || off > lim) begin
			dlt = tgt - $signed({off[31], off});
			noff = $signed({off[31], off}) + (dlt >>> 2);
			r.spd = 32'sd0;
			if ((noff - tgt) < SNAP_DIST && (tgt - noff) < SNAP_DIST) begin
				r.off = tgt[31:0];
			end else begin
				r.off = noff[31:0];
				r.act = 1'b1;
			end
		end else if (spd != 0) begin
			r.off = sat32(ext32(off) + ext32(spd));
			if (r.off < 0 || r.off > lim) begin
				r.spd = 32'sd0;
				r.act = 1'b1;
			end else begin
				fr = ($signed({{5{spd[31]}}, spd}) <<< 4) - $signed({{5{spd[31]}}, spd});
				if (fr < 0) fr = fr + 37'sd15;
				frs = fr >>> 4;
				ns = frs[31:0];
				if (ns < MIN_SPEED && ns > -MIN_SPEED) begin
					r.spd = 32'sd0;
					rnd = {1'b0, r.off} + HALF_UNIT;
					r.off = $signed(rnd[31:0] & INT_MASK);
				end else begin
					r.spd = ns;
					r.act = 1'b1;
				end
			end
		end
		return r;
	endfunction

	logic [ISP_LIM_W-1:0] max_x_q, max_y_q;
	logic                 drag_q, motion_q;
	logic signed [15:0]   press_x_q, press_y_q, prev_x_q, prev_y_q;
	logic signed [31:0]   start_x_q, start_y_q, cur_x_q, cur_y_q, spd_x_q, spd_y_q;

	logic        valid_s1;
	isp_item_t   item_s1;
	logic        res_valid_q;
	isp_result_t res_q;
	logic        adv;
	logic        cfg_wr;

	logic               drag_d, motion_d, redraw_d, start_wr;
	logic signed [31:0] cur_x_d, cur_y_d, spd_x_d, spd_y_d;
	logic signed [31:0] lim_x, lim_y;
	logic signed [31:0] raw_x, raw_y, set_x, set_y;
	logic signed [W-1:0] ema_x, ema_y, ema_xr, ema_yr, req_x, req_y;
	logic               out_x, out_y;
	axis_t              ax, ay;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= '0;
			max_y_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				ISP_REG_MAX_X: max_x_q <= pwdata[ISP_LIM_W-1:0];
				ISP_REG_MAX_Y: max_y_q <= pwdata[ISP_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ISP_REG_MAX_X: prdata = {{(32-ISP_LIM_W){1'b0}}, max_x_q};
			ISP_REG_MAX_Y: prdata = {{(32-ISP_LIM_W){1'b0}}, max_y_q};
			default:       prdata = '0;
		endcase
	end

	assign adv          = !res_valid_q || !result_stall;
	assign item_stall   = valid_s1 && !adv;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!item_stall) valid_s1 <= item_valid;
			if (adv) res_valid_q <= valid_s1;
		end
	end

	assign lim_x = $signed({{(32-ISP_LIM_W){1'b0}}, max_x_q}) <<< FRAC_BITS;
	assign lim_y = $signed({{(32-ISP_LIM_W){1'b0}}, max_y_q}) <<< FRAC_BITS;

	always_comb begin
		raw_x  = sat32(ext32(start_x_q) + ((ext16(press_x_q) - ext16(item_s1.pos_x)) <<< FRAC_BITS));
		raw_y  = sat32(ext32(start_y_q) + ((ext16(press_y_q) - ext16(item_s1.pos_y)) <<< FRAC_BITS));
		ema_x  = ext32(spd_x_q) + (ext32(spd_x_q) <<< 1) +
			((((ext16(prev_x_q) - ext16(item_s1.pos_x)) <<< 2) +
			(ext16(prev_x_q) - ext16(item_s1.pos_x))) <<< FRAC_BITS);
		ema_y  = ext32(spd_y_q) + (ext32(spd_y_q) <<< 1) +
			((((ext16(prev_y_q) - ext16(item_s1.pos_y)) <<< 2) +
			(ext16(prev_y_q) - ext16(item_s1.pos_y))) <<< FRAC_BITS);
		ema_xr = ((ema_x < 0) ? ema_x + W'(7) : ema_x) >>> 3;
		ema_yr = ((ema_y < 0) ? ema_y + W'(7) : ema_y) >>> 3;
		req_x  = ext16(item_s1.pos_x) <<< FRAC_BITS;
		req_y  = ext16(item_s1.pos_y) <<< FRAC_BITS;
		set_x  = (req_x < 0) ? 32'sd0 : ((req_x > ext32(lim_x)) ? lim_x : req_x[31:0]);
		set_y  = (req_y < 0) ? 32'sd0 : ((req_y > ext32(lim_y)) ? lim_y : req_y[31:0]);
		out_x  = cur_x_q < 0 || cur_x_q > lim_x;
		out_y  = cur_y_q < 0 || cur_y_q > lim_y;
		ax     = step_axis(cur_x_q, spd_x_q, lim_x);
		ay     = step_axis(cur_y_q, spd_y_q, lim_y);

		drag_d   = drag_q;
		motion_d = motion_q;
		redraw_d = 1'b0;
		start_wr = 1'b0;
		cur_x_d  = cur_x_q;
		cur_y_d  = cur_y_q;
		spd_x_d  = spd_x_q;
		spd_y_d  = spd_y_q;
		case (item_s1.kind)
			ISP_KIND_DOWN: begin
				drag_d   = 1'b1;
				motion_d = 1'b0;
				start_wr = 1'b1;
				spd_x_d  = 32'sd0;
				spd_y_d  = 32'sd0;
			end
			ISP_KIND_MOVE: begin
				if (drag_q) begin
					cur_x_d  = half_rate(raw_x, lim_x);
					cur_y_d  = half_rate(raw_y, lim_y);
					spd_x_d  = sat32(ema_xr);
					spd_y_d  = sat32(ema_yr);
					redraw_d = (cur_x_d != cur_x_q) || (cur_y_d != cur_y_q);
				end
			end
			ISP_KIND_UP: begin
				if (drag_q) begin
					drag_d = 1'b0;
					if (out_x) spd_x_d = 32'sd0;
					if (out_y) spd_y_d = 32'sd0;
					if (out_x || out_y ||
							spd_x_d > MIN_SPEED || spd_x_d < -MIN_SPEED ||
							spd_y_d > MIN_SPEED || spd_y_d < -MIN_SPEED) begin
						motion_d = 1'b1;
					end else begin
						spd_x_d = 32'sd0;
						spd_y_d = 32'sd0;
					end
				end
			end
			ISP_KIND_TICK: begin
				if (motion_q) begin
					cur_x_d  = ax.off;
					cur_y_d  = ay.off;
					spd_x_d  = ax.spd;
					spd_y_d  = ay.spd;
					redraw_d = 1'b1;
					motion_d = ax.act || ay.act;
				end
			end
			ISP_KIND_SET: begin
				if (set_x != cur_x_q || set_y != cur_y_q) begin
					cur_x_d  = set_x;
					cur_y_d  = set_y;
					redraw_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q   <= 1'b0;
			motion_q <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			spd_x_q  <= '0;
			spd_y_q  <= '0;
		end else if (adv && valid_s1) begin
			drag_q   <= drag_d;
			motion_q <= motion_d;
			cur_x_q  <= cur_x_d;
			cur_y_q  <= cur_y_d;
			spd_x_q  <= spd_x_d;
			spd_y_q  <= spd_y_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) item_s1 <= item;
		if (adv && valid_s1) begin
			res_q.offset_x     <= cur_x_d;
			res_q.offset_y     <= cur_y_d;
			res_q.redraw       <= redraw_d;
			res_q.animating    <= motion_d;
			res_q.dragging_now <= drag_d;
			if (start_wr) begin
				press_x_q <= item_s1.pos_x;
				press_y_q <= item_s1.pos_y;
				start_x_q <= cur_x_q;
				start_y_q <= cur_y_q;
			end
			if (start_wr || (item_s1.kind == ISP_KIND_MOVE && drag_q)) begin
				prev_x_q <= item_s1.pos_x;
				prev_y_q <= item_s1.pos_y;
			end
		end
	end

	`ISP_ASSERT_NOW(a_drag_motion_excl, 1'b1, !(drag_q && motion_q), "drag and motion both active")
	`ISP_ASSERT_NOW(a_idle_no_speed, !drag_q && !motion_q, spd_x_q == 0 && spd_y_q == 0, "speed left at rest")
	`ISP_ASSERT_NEXT(a_tick_redraw, adv && valid_s1 && item_s1.kind == ISP_KIND_TICK && motion_q, result_valid && result.redraw, "animated tick without redraw")
	`ISP_ASSERT_NOW(a_stall_needs_item, item_stall, valid_s1 && res_valid_q && result_stall, "input held without a blocked result")

endmodule

// File: tb/testbench.sv
module testbench;
	import isp_pkg::*;

	localparam longint ONE          = longint'(1) << ISP_FRAC_BITS;
	localparam longint MIN_SPEED    = ONE / 5;
	localparam longint SNAP_DIST    = ONE / 4;
	localparam longint S32_MAX      = 64'sd2147483647;
	localparam longint S32_MIN      = -64'sd2147483648;
	localparam int     HOLD_CYCLES  = 200;
	localparam int     DRAIN_CYCLES = 4;
	localparam int     IDLE_LIMIT   = 3000;
	localparam int     RANDOM_ITEMS = 300;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_e;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ISP_ADDR_W-1:0]   paddr = '0;
	logic [31:0]             pwdata = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	isp_item_t               item = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	isp_result_t             result;

	// scroll state mirror, index 0 is x and 1 is y
	bit     drag_on;
	bit     motion_on;
	longint press_pos[2];
	longint prev_pos[2];
	longint anchor_off[2];
	longint view_off[2];
	longint view_speed[2];
	longint limit_px[2];

	isp_result_t predicted_views[$];
	int          items_sent;
	int          mismatches;
	int          burst_left;
	int          idle_cycles;
	bit          hold_req;
	int          hold_left;
	int          mode_left;
	stall_mode_e stall_mode;
	bit          stall_phase;

	inertial_scroll_physics_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #6 clk = ~clk;

	function automatic longint saturate32(longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	function automatic longint limit_fx(int a);
		return limit_px[a] * ONE;
	endfunction

	function automatic longint rubber_band(longint raw, longint lim);
		if (raw < 0) return raw / 2;
		if (raw > lim) return lim + (raw - lim) / 2;
		return raw;
	endfunction

	function automatic longint clamp_to_range(longint v, longint lim);
		if (v < 0) return 0;
		if (v > lim) return lim;
		return v;
	endfunction

	function automatic bit advance_axis(int a);
		longint lim;
		longint target;
		lim = limit_fx(a);
		if (view_off[a] < 0 || view_off[a] > lim) begin
			target = (view_off[a] < 0) ? 0 : lim;
			view_speed[a] = 0;
			view_off[a] = view_off[a] + ((target - view_off[a]) >>> 2);
			if (view_off[a] - target < SNAP_DIST && target - view_off[a] < SNAP_DIST) begin
				view_off[a] = target;
				return 1'b0;
			end
			return 1'b1;
		end
		if (view_speed[a] == 0) return 1'b0;
		view_off[a] = saturate32(view_off[a] + view_speed[a]);
		if (view_off[a] < 0 || view_off[a] > lim) begin
			view_speed[a] = 0;
			return 1'b1;
		end
		view_speed[a] = view_speed[a] * 15 / 16;
		if (view_speed[a] < MIN_SPEED && view_speed[a] > -MIN_SPEED) begin
			view_speed[a] = 0;
			view_off[a] = (view_off[a] + ONE / 2) & ~(ONE - 1);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic isp_result_t scroll_step(isp_item_t it);
		isp_result_t r;
		longint      pos[2];
		longint      old_off[2];
		longint      next_off[2];
		bit          redraw;
		bit          moving;
		bit          live;
		pos[0] = longint'($signed(it.pos_x));
		pos[1] = longint'($signed(it.pos_y));
		redraw = 1'b0;
		case (it.kind)
			ISP_KIND_DOWN: begin
				drag_on = 1'b1;
				motion_on = 1'b0;
				for (int a = 0; a < 2; a++) begin
					press_pos[a] = pos[a];
					prev_pos[a] = pos[a];
					anchor_off[a] = view_off[a];
					view_speed[a] = 0;
				end
			end
			ISP_KIND_MOVE: if (drag_on) begin
				for (int a = 0; a < 2; a++) begin
					old_off[a] = view_off[a];
					view_off[a] = saturate32(rubber_band(
						saturate32(anchor_off[a] + (press_pos[a] - pos[a]) * ONE), limit_fx(a)));
					view_speed[a] = saturate32((view_speed[a] * 3
						+ (prev_pos[a] - pos[a]) * ONE * 5) / 8);
					prev_pos[a] = pos[a];
					if (old_off[a] != view_off[a]) redraw = 1'b1;
				end
			end
			ISP_KIND_UP: if (drag_on) begin
				drag_on = 1'b0;
				moving = 1'b0;
				for (int a = 0; a < 2; a++) begin
					if (view_off[a] < 0 || view_off[a] > limit_fx(a)) begin
						view_speed[a] = 0;
						moving = 1'b1;
					end else if (view_speed[a] > MIN_SPEED || view_speed[a] < -MIN_SPEED) begin
						moving = 1'b1;
					end
				end
				if (moving) motion_on = 1'b1;
				else begin
					view_speed[0] = 0;
					view_speed[1] = 0;
				end
			end
			ISP_KIND_TICK: if (motion_on) begin
				live = 1'b0;
				for (int a = 0; a < 2; a++)
					if (advance_axis(a)) live = 1'b1;
				redraw = 1'b1;
				if (!live) motion_on = 1'b0;
			end
			ISP_KIND_SET: begin
				for (int a = 0; a < 2; a++)
					next_off[a] = clamp_to_range(pos[a] * ONE, limit_fx(a));
				if (next_off[0] != view_off[0] || next_off[1] != view_off[1]) begin
					view_off[0] = next_off[0];
					view_off[1] = next_off[1];
					redraw = 1'b1;
				end
			end
			default: ;
		endcase
		r.offset_x     = view_off[0][31:0];
		r.offset_y     = view_off[1][31:0];
		r.redraw       = redraw;
		r.animating    = motion_on;
		r.dragging_now = drag_on;
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		isp_result_t want;
		isp_result_t got;
		if (arst_n && result_valid && !result_stall) begin
			got = result;
			if (predicted_views.size() == 0) begin
				$error("result with no item pending: offset_x %0d offset_y %0d",
					got.offset_x, got.offset_y);
				mismatches++;
			end else begin
				want = predicted_views.pop_front();
				check_field("offset_x", want.offset_x, got.offset_x);
				check_field("offset_y", want.offset_y, got.offset_y);
				check_field("redraw", want.redraw, got.redraw);
				check_field("animating", want.animating, got.animating);
				check_field("dragging_now", want.dragging_now, got.dragging_now);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 120);
		end
		mode_left--;
		stall_phase = ~stall_phase;
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
				default:     result_stall <= stall_phase;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[inertial_scroll_physics_top] ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [2:0] kind, input logic [15:0] px, input logic [15:0] py);
		isp_item_t it;
		int        gap;
		it.kind  = kind;
		it.pos_x = px;
		it.pos_y = py;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
			gap = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predicted_views.push_back(scroll_step(it));
		items_sent++;
		burst_left--;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (predicted_views.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic sel, input int unsigned px);
		logic [16:0] upper;
		upper = 17'($urandom);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {upper, 15'(px)};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		limit_px[sel] = longint'(px & 32'h7fff);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_limits(input int unsigned x, input int unsigned y);
		wait_drained();
		write_limit(ISP_REG_MAX_X, x);
		write_limit(ISP_REG_MAX_Y, y);
	endtask

	task automatic tick_until_still(input int cap);
		int n;
		n = 0;
		while (motion_on && n < cap) begin
			send_item(ISP_KIND_TICK, 16'($urandom), 16'($urandom));
			n++;
		end
	endtask

	function automatic int unsigned pick_limit();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 32767;
			2:       return $urandom_range(1, 3000);
			default: return $urandom_range(0, 32767);
		endcase
	endfunction

	task automatic random_noise();
		send_item(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
	endtask

	task automatic random_gesture();
		logic [15:0] tx;
		logic [15:0] ty;
		int          moves;
		tx = 16'($urandom);
		ty = 16'($urandom);
		if ($urandom_range(0, 4) == 0)
			send_item(ISP_KIND_SET, 16'($urandom_range(0, int'(limit_px[0]))),
				16'($urandom_range(0, int'(limit_px[1]))));
		send_item(ISP_KIND_DOWN, tx, ty);
		moves = $urandom_range(0, 8);
		repeat (moves) begin
			if ($urandom_range(0, 9) == 0) begin
				tx = 16'($urandom);
				ty = 16'($urandom);
			end else begin
				tx = tx + 16'($urandom_range(0, 80)) - 16'd40;
				ty = ty + 16'($urandom_range(0, 80)) - 16'd40;
			end
			send_item(ISP_KIND_MOVE, tx, ty);
		end
		if ($urandom_range(0, 9) != 0)
			send_item(ISP_KIND_UP, tx, ty);
		tick_until_still($urandom_range(0, 1) ? 200 : $urandom_range(0, 20));
	endtask

	task automatic test_idle_rules();
		send_item(ISP_KIND_TICK, 16'h0000, 16'hffff);
		send_item(ISP_KIND_MOVE, 16'h1234, 16'h8000);
		send_item(ISP_KIND_UP, 16'h7fff, 16'h0001);
		send_item(3'd5, 16'hffff, 16'hffff);
		send_item(3'd6, 16'h5555, 16'haaaa);
		send_item(3'd7, 16'haaaa, 16'h5555);
		send_item(ISP_KIND_SET, 16'sd32767, -16'sd32768);
		send_item(ISP_KIND_SET, -16'sd1, 16'sd1);
	endtask

	task automatic test_drag_limits();
		set_limits(1000, 500);
		send_item(ISP_KIND_SET, 16'sd500, 16'sd250);
		send_item(ISP_KIND_SET, 16'sd500, 16'sd250);
		send_item(ISP_KIND_DOWN, 16'sd0, 16'sd0);
		send_item(ISP_KIND_MOVE, -16'sd32768, 16'sd32767);
		send_item(ISP_KIND_MOVE, -16'sd32768, 16'sd32767);
		send_item(ISP_KIND_UP, -16'sd32768, 16'sd32767);
		tick_until_still(80);
	endtask

	task automatic test_momentum();
		send_item(ISP_KIND_SET, 16'sd300, 16'sd200);
		send_item(ISP_KIND_DOWN, 16'sd100, 16'sd100);
		send_item(ISP_KIND_MOVE, 16'sd96, 16'sd98);
		send_item(ISP_KIND_MOVE, 16'sd88, 16'sd95);
		send_item(ISP_KIND_MOVE, 16'sd70, 16'sd90);
		send_item(ISP_KIND_MOVE, 16'sd40, 16'sd80);
		send_item(ISP_KIND_UP, 16'sd40, 16'sd80);
		tick_until_still(5);
		send_item(ISP_KIND_DOWN, 16'sd0, 16'sd0);
		send_item(ISP_KIND_DOWN, 16'sd10, 16'sd10);
		send_item(ISP_KIND_MOVE, 16'sd12, 16'sd9);
		send_item(ISP_KIND_UP, 16'sd12, 16'sd9);
		tick_until_still(100);
		send_item(ISP_KIND_DOWN, 16'sd5, 16'sd5);
		send_item(ISP_KIND_UP, 16'sd5, 16'sd5);
		send_item(ISP_KIND_TICK, 16'sd0, 16'sd0);
		send_item(ISP_KIND_SET, 16'sd960, 16'sd5);
		send_item(ISP_KIND_DOWN, 16'sd0, 16'sd0);
		send_item(ISP_KIND_MOVE, -16'sd8, 16'sd0);
		send_item(ISP_KIND_MOVE, -16'sd16, 16'sd0);
		send_item(ISP_KIND_MOVE, -16'sd24, 16'sd0);
		send_item(ISP_KIND_UP, -16'sd24, 16'sd0);
		tick_until_still(100);
	endtask

	task automatic test_limit_extremes();
		set_limits(32767, 0);
		send_item(ISP_KIND_SET, 16'sd32767, 16'sd32767);
		send_item(ISP_KIND_DOWN, 16'sd32767, 16'sd32767);
		send_item(ISP_KIND_MOVE, -16'sd32768, -16'sd32768);
		send_item(ISP_KIND_MOVE, 16'sd32767, 16'sd32767);
		send_item(ISP_KIND_MOVE, -16'sd32768, -16'sd32768);
		send_item(ISP_KIND_UP, -16'sd32768, -16'sd32768);
		tick_until_still(10);
		send_item(ISP_KIND_DOWN, -16'sd32768, -16'sd32768);
		send_item(ISP_KIND_MOVE, 16'sd32767, 16'sd32767);
		send_item(ISP_KIND_UP, 16'sd32767, 16'sd32767);
		set_limits(0, 32767);
		tick_until_still(200);
	endtask

	task automatic test_backpressure();
		logic [15:0] tx;
		logic [15:0] ty;
		tx = 16'($urandom);
		ty = 16'($urandom);
		hold_req = 1'b1;
		send_item(ISP_KIND_DOWN, tx, ty);
		repeat (12) begin
			tx = tx + 16'($urandom_range(0, 60)) - 16'd30;
			ty = ty + 16'($urandom_range(0, 60)) - 16'd30;
			send_item(ISP_KIND_MOVE, tx, ty);
		end
		send_item(ISP_KIND_UP, tx, ty);
		repeat (20) send_item(ISP_KIND_TICK, 16'($urandom), 16'($urandom));
	endtask

	task automatic test_drain_pause();
		repeat (3) begin
			repeat (6) random_noise();
			wait_drained();
		end
	endtask

	task automatic test_random_gestures();
		int goal;
		int phase_start;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			set_limits(pick_limit(), pick_limit());
			phase_start = items_sent;
			while (items_sent - phase_start < 110 && items_sent < goal) begin
				if ($urandom_range(0, 9) < 7) random_gesture();
				else random_noise();
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_rules();
		test_drag_limits();
		test_momentum();
		test_limit_extremes();
		test_backpressure();
		test_drain_pause();
		test_random_gestures();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[inertial_scroll_physics_top] OK");
		else
			$display("[inertial_scroll_physics_top] ERROR");
		$finish;
	end

endmodule
